>>> design/turing_machine_step_engine_defines.svh
// Assertion macros shared by the step engine.
`ifndef TURING_MACHINE_STEP_ENGINE_DEFINES_SVH
`define TURING_MACHINE_STEP_ENGINE_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define TMSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define TMSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tmse_pkg.sv
`timescale 1ns / 1ps

package tmse_pkg;

    localparam int STATE_W     = 4;
    localparam int SYM_W       = 3;
    localparam int MOVE_W      = 2;
    localparam int OP_W        = 3;
    localparam int POS_W       = 10;
    localparam int STATUS_W    = 3;
    localparam int TAPE_DEPTH  = 1024;
    localparam int TAPE_AW     = $clog2(TAPE_DEPTH);
    localparam int RULE_AW     = STATE_W + SYM_W;
    localparam int RULE_DEPTH  = 2 ** RULE_AW;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_FIELDS_W = OP_W + STATE_W + 2 * SYM_W + MOVE_W + STATE_W + POS_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATE_W + POS_W + 1 + SYM_W + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_LOAD_RULE   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR_RULES = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_CELL  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET_RUN   = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_HEAD    = 3'd4;
    localparam logic [OP_W-1:0] OP_STEP        = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_CELL   = 3'd6;

    localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd1;
    localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_RULE  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_HALT     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_OFF_TAPE = 3'd4;
    localparam logic [STATUS_W-1:0] STS_HALTED   = 3'd5;

    localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_STATE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALT_STATE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHABET_MASK = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STATE_MASK    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_INDEX   = 3'd4;

    localparam logic [STATE_W-1:0]      RST_INITIAL_STATE = 4'd0;
    localparam logic [STATE_W-1:0]      RST_HALT_STATE    = 4'd1;
    localparam logic [2**SYM_W-1:0]     RST_ALPHABET_MASK = 8'd1;
    localparam logic [2**STATE_W-1:0]   RST_STATE_MASK    = 16'd3;
    localparam logic [POS_W-1:0]        RST_START_INDEX   = 10'd512;

    localparam logic [SYM_W-1:0] BLANK_CODE = '0;

    typedef struct packed {
        logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
        logic [POS_W-1:0]   position;
        logic [STATE_W-1:0] next_state;
        logic [MOVE_W-1:0]  move;
        logic [SYM_W-1:0]   write_symbol;
        logic [SYM_W-1:0]   rule_symbol;
        logic [STATE_W-1:0] rule_state;
        logic [OP_W-1:0]    op;
    } in_word_t;

    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    seen_symbol;
        logic                is_halted;
        logic [POS_W-1:0]    head_now;
        logic [STATE_W-1:0]  state_now;
    } out_word_t;

    typedef struct packed {
        logic [SYM_W-1:0]   wsym;
        logic [MOVE_W-1:0]  mv;
        logic [STATE_W-1:0] nq;
    } rule_ent_t;

    typedef struct packed {
        logic               en;
        logic [RULE_AW-1:0] addr;
        rule_ent_t          data;
    } rule_wr_t;

    typedef struct packed {
        logic               en;
        logic [TAPE_AW-1:0] addr;
        logic [SYM_W-1:0]   data;
    } tape_wr_t;

endpackage

>>> design/tmse_tape.sv
`timescale 1ns / 1ps

module tmse_tape (
    input  logic                          aclk,
    input  tmse_pkg::tape_wr_t            wr,
    input  logic [tmse_pkg::TAPE_AW-1:0]  rd_addr,
    output logic [tmse_pkg::SYM_W-1:0]    rd_data
);
    import tmse_pkg::*;

    logic [SYM_W-1:0] mem [TAPE_DEPTH];
    logic [SYM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/tmse_rules.sv
`timescale 1ns / 1ps

module tmse_rules (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  tmse_pkg::rule_wr_t            wr,
    input  logic [tmse_pkg::RULE_AW-1:0]  rd_addr,
    output tmse_pkg::rule_ent_t           rd_data,
    output logic                          rd_valid
);
    import tmse_pkg::*;

    rule_ent_t              mem [RULE_DEPTH];
    logic [RULE_DEPTH-1:0]  valid_reg;
    rule_ent_t              rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> design/turing_machine_step_engine.sv
`timescale 1ns / 1ps
`include "turing_machine_step_engine_defines.svh"

// Single-tape Turing machine with a 1024-cell tape held in a synchronous RAM and a
// 128-entry rule RAM whose valid bits live in flip-flops, so all rules are cleared
// together. One word is worked on at a time and every word returns one result word.
// Load rule, clear rules, write cell, set head, read cell and the undefined op go from
// acceptance to a result in the output register by action, tape read and result. A step
// goes by tape read under the head, rule read, tape write-back with head and state update,
// tape read at the new head and result. A run reset clears the tape one cell a cycle, then
// reads the tape and gives its result. After aresetn the same clearing pass runs before
// the first word is accepted; configuration writes are taken during it. The output
// register lets the next word be accepted while a result still waits on m_tready.
module turing_machine_step_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tmse_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tmse_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op, rule_state, rule_symbol, write_symbol, move, next_state, position, zero fill
    input  logic [tmse_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // state_now, head_now, is_halted, seen_symbol, status, zero fill
    output logic [tmse_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tmse_pkg::*;

    localparam logic [2:0] S_INIT_CLR = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CLEAR    = 3'd2;
    localparam logic [2:0] S_STEP_RD  = 3'd3;
    localparam logic [2:0] S_STEP_WR  = 3'd4;
    localparam logic [2:0] S_RD       = 3'd5;
    localparam logic [2:0] S_RES      = 3'd6;

    logic [STATE_W-1:0]     init_reg;
    logic [STATE_W-1:0]     halt_reg;
    logic [2**SYM_W-1:0]    alpha_reg;
    logic [2**STATE_W-1:0]  smask_reg;
    logic [POS_W-1:0]       start_reg;

    logic [2:0]             st_reg, st_next;
    logic [TAPE_AW-1:0]     head_reg, head_next;
    logic [STATE_W-1:0]     cur_reg, cur_next;
    logic                   halted_reg, halted_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [TAPE_AW-1:0]     pos_reg, pos_next;
    logic                   pos_sel_reg, pos_sel_next;
    logic                   blank_reg, blank_next;
    logic [TAPE_AW-1:0]     clr_reg, clr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    out_word_t              out_reg, out_next;

    in_word_t               in_w;
    logic                   accept;
    logic                   sym_ok;
    logic                   wsym_ok;
    logic                   next_ok;
    logic                   pos_ok;
    logic [TAPE_AW-1:0]     start_pos;
    logic                   last_cell;

    tape_wr_t               tape_wr;
    logic [TAPE_AW-1:0]     tape_rd_addr;
    logic [SYM_W-1:0]       tape_rdata;
    rule_wr_t               rule_wr;
    logic                   rule_clear;
    logic [RULE_AW-1:0]     rule_rd_addr;
    rule_ent_t              rule_rdata;
    logic                   rule_valid;

    assign in_w      = in_word_t'(s_tdata);
    assign s_tready  = (st_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign sym_ok    = (in_w.rule_symbol == BLANK_CODE) || alpha_reg[in_w.rule_symbol];
    assign wsym_ok   = (in_w.write_symbol == BLANK_CODE) || alpha_reg[in_w.write_symbol];
    assign next_ok   = (in_w.next_state == halt_reg) || smask_reg[in_w.next_state];
    assign pos_ok    = int'(in_w.position) < TAPE_DEPTH;
    assign start_pos = (int'(start_reg) < TAPE_DEPTH) ? start_reg[TAPE_AW-1:0]
                                                      : TAPE_AW'(TAPE_DEPTH - 1);
    assign last_cell = (clr_reg == TAPE_AW'(TAPE_DEPTH - 1));

    assign tape_rd_addr = ((st_reg == S_RD || st_reg == S_RES) && pos_sel_reg) ? pos_reg
                                                                               : head_reg;
    assign rule_rd_addr = {cur_reg, tape_rdata};

    tmse_tape u_tape (
        .aclk    (aclk),
        .wr      (tape_wr),
        .rd_addr (tape_rd_addr),
        .rd_data (tape_rdata)
    );

    tmse_rules u_rules (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (rule_clear),
        .wr       (rule_wr),
        .rd_addr  (rule_rd_addr),
        .rd_data  (rule_rdata),
        .rd_valid (rule_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg  <= RST_INITIAL_STATE;
            halt_reg  <= RST_HALT_STATE;
            alpha_reg <= RST_ALPHABET_MASK;
            smask_reg <= RST_STATE_MASK;
            start_reg <= RST_START_INDEX;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_INITIAL_STATE: init_reg  <= cfg_wdata[STATE_W-1:0];
                CFG_HALT_STATE:    halt_reg  <= cfg_wdata[STATE_W-1:0];
                CFG_ALPHABET_MASK: alpha_reg <= cfg_wdata[2**SYM_W-1:0];
                CFG_STATE_MASK:    smask_reg <= cfg_wdata[2**STATE_W-1:0];
                CFG_START_INDEX:   start_reg <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        st_next       = st_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        halted_next   = halted_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        pos_sel_next  = pos_sel_reg;
        blank_next    = blank_reg;
        clr_next      = clr_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        tape_wr       = '0;
        rule_wr       = '0;
        rule_clear    = 1'b0;

        case (st_reg)
            S_INIT_CLR, S_CLEAR: begin
                tape_wr.en   = 1'b1;
                tape_wr.addr = clr_reg;
                tape_wr.data = BLANK_CODE;
                if (last_cell) begin
                    st_next = (st_reg == S_CLEAR) ? S_RD : S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    status_next  = STS_OK;
                    pos_sel_next = 1'b0;
                    blank_next   = 1'b0;
                    pos_next     = in_w.position[TAPE_AW-1:0];
                    st_next      = S_RD;
                    case (in_w.op)
                        OP_LOAD_RULE: begin
                            if (sym_ok && wsym_ok && next_ok) begin
                                rule_wr.en        = 1'b1;
                                rule_wr.addr      = {in_w.rule_state, in_w.rule_symbol};
                                rule_wr.data.wsym = in_w.write_symbol;
                                rule_wr.data.mv   = in_w.move;
                                rule_wr.data.nq   = in_w.next_state;
                            end else begin
                                status_next = STS_REJECTED;
                            end
                        end
                        OP_CLEAR_RULES: begin
                            rule_clear = 1'b1;
                        end
                        OP_WRITE_CELL: begin
                            tape_wr.en   = pos_ok;
                            tape_wr.addr = in_w.position[TAPE_AW-1:0];
                            tape_wr.data = in_w.rule_symbol;
                        end
                        OP_RESET_RUN: begin
                            head_next   = start_pos;
                            cur_next    = init_reg;
                            halted_next = 1'b0;
                            clr_next    = '0;
                            st_next     = S_CLEAR;
                        end
                        OP_SET_HEAD: begin
                            if (pos_ok) begin
                                head_next = in_w.position[TAPE_AW-1:0];
                            end
                        end
                        OP_STEP: begin
                            if (halted_reg) begin
                                status_next = STS_HALTED;
                            end else begin
                                st_next = S_STEP_RD;
                            end
                        end
                        OP_READ_CELL: begin
                            pos_sel_next = 1'b1;
                            blank_next   = !pos_ok;
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP_RD: begin
                st_next = S_STEP_WR;
            end
            S_STEP_WR: begin
                st_next = S_RD;
                if (!rule_valid) begin
                    halted_next = 1'b1;
                    status_next = STS_NO_RULE;
                end else begin
                    tape_wr.en   = 1'b1;
                    tape_wr.addr = head_reg;
                    tape_wr.data = rule_rdata.wsym;
                    cur_next     = rule_rdata.nq;
                    if ((rule_rdata.mv == MV_LEFT && head_reg == '0) ||
                        (rule_rdata.mv == MV_RIGHT &&
                         head_reg == TAPE_AW'(TAPE_DEPTH - 1))) begin
                        halted_next = 1'b1;
                        status_next = STS_OFF_TAPE;
                    end else begin
                        if (rule_rdata.mv == MV_LEFT) begin
                            head_next = head_reg - 1'b1;
                        end else if (rule_rdata.mv == MV_RIGHT) begin
                            head_next = head_reg + 1'b1;
                        end
                        if (rule_rdata.nq == halt_reg) begin
                            halted_next = 1'b1;
                            status_next = STS_HALT;
                        end
                    end
                end
            end
            S_RD: begin
                st_next = S_RES;
            end
            S_RES: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next        = 1'b1;
                    out_next             = '0;
                    out_next.state_now   = cur_reg;
                    out_next.head_now    = POS_W'(head_reg);
                    out_next.is_halted   = halted_reg;
                    out_next.seen_symbol = blank_reg ? BLANK_CODE : tape_rdata;
                    out_next.status      = status_reg;
                    st_next              = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_INIT_CLR;
            head_reg     <= RST_START_INDEX[TAPE_AW-1:0];
            cur_reg      <= RST_INITIAL_STATE;
            halted_reg   <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            head_reg     <= head_next;
            cur_reg      <= cur_next;
            halted_reg   <= halted_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        pos_sel_reg <= pos_sel_next;
        blank_reg   <= blank_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    `TMSE_ASSERT_NEXT(a_one_word_at_a_time, s_tvalid && s_tready, !s_tready, "word accepted while busy")
    `TMSE_ASSERT_NOW(a_halt_has_cause, $rose(halted_reg), status_reg == STS_NO_RULE || status_reg == STS_HALT || status_reg == STS_OFF_TAPE, "halt without a halting status")
    `TMSE_ASSERT_NOW(a_result_from_res, $rose(m_tvalid_reg), $past(st_reg) == S_RES, "result raised outside result state")

endmodule

>>> tb/turing_machine_step_engine_tb.sv
`timescale 1ns / 1ps

module turing_machine_step_engine_tb;
    import tmse_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNDEFINED = 3'd7;
    localparam logic [MOVE_W-1:0] MV_STAY      = 2'd0;
    localparam logic [MOVE_W-1:0] MV_CODE3     = 2'd3;
    localparam logic [POS_W-1:0]  LAST_CELL    = POS_W'(TAPE_DEPTH - 1);
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_WORDS  = 200;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } vec_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [STATE_W-1:0]    cfg_init;
    logic [STATE_W-1:0]    cfg_halt;
    logic [2**SYM_W-1:0]   cfg_alpha;
    logic [2**STATE_W-1:0] cfg_smask;
    logic [POS_W-1:0]      cfg_start;

    bit                 rule_ok [RULE_DEPTH];
    rule_ent_t          rule_mem [RULE_DEPTH];
    logic [SYM_W-1:0]   tape_img [TAPE_DEPTH];
    logic [POS_W-1:0]   tm_head;
    logic [STATE_W-1:0] tm_state;
    logic               tm_halted;

    out_word_t report_q [$];
    vec_row_t  dir_rows [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned rx_wait = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    out_word_t rx_got;
    out_word_t rx_want;
    int unsigned rx_roll;

    turing_machine_step_engine u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit sym_allowed(input logic [SYM_W-1:0] s);
        return (s == BLANK_CODE) || cfg_alpha[s];
    endfunction

    function automatic bit next_allowed(input logic [STATE_W-1:0] q);
        return (q == cfg_halt) || cfg_smask[q];
    endfunction

    task automatic tm_apply(input in_word_t w, output out_word_t o);
        logic [RULE_AW-1:0]  idx;
        rule_ent_t           ent;
        logic                off;
        logic                rd;
        logic [SYM_W-1:0]    rd_val;
        logic [STATUS_W-1:0] sts;
        sts = STS_OK;
        rd = 1'b0;
        rd_val = BLANK_CODE;
        off = 1'b0;
        case (w.op)
            OP_LOAD_RULE: begin
                if (!sym_allowed(w.rule_symbol) || !sym_allowed(w.write_symbol)
                        || !next_allowed(w.next_state)) begin
                    sts = STS_REJECTED;
                end else begin
                    idx = {w.rule_state, w.rule_symbol};
                    rule_ok[idx] = 1'b1;
                    rule_mem[idx] = '{wsym: w.write_symbol, mv: w.move, nq: w.next_state};
                end
            end
            OP_CLEAR_RULES: begin
                foreach (rule_ok[i]) rule_ok[i] = 1'b0;
            end
            OP_WRITE_CELL: begin
                tape_img[w.position] = w.rule_symbol;
            end
            OP_RESET_RUN: begin
                foreach (tape_img[i]) tape_img[i] = BLANK_CODE;
                tm_head = cfg_start;
                tm_state = cfg_init;
                tm_halted = 1'b0;
            end
            OP_SET_HEAD: begin
                tm_head = w.position;
            end
            OP_STEP: begin
                if (tm_halted) begin
                    sts = STS_HALTED;
                end else begin
                    idx = {tm_state, tape_img[tm_head]};
                    if (!rule_ok[idx]) begin
                        tm_halted = 1'b1;
                        sts = STS_NO_RULE;
                    end else begin
                        ent = rule_mem[idx];
                        tape_img[tm_head] = ent.wsym;
                        if (ent.mv == MV_LEFT) begin
                            if (tm_head == '0) off = 1'b1;
                            else tm_head = tm_head - 1'b1;
                        end else if (ent.mv == MV_RIGHT) begin
                            if (tm_head == LAST_CELL) off = 1'b1;
                            else tm_head = tm_head + 1'b1;
                        end
                        tm_state = ent.nq;
                        if (off) begin
                            tm_halted = 1'b1;
                            sts = STS_OFF_TAPE;
                        end else if (tm_state == cfg_halt) begin
                            tm_halted = 1'b1;
                            sts = STS_HALT;
                        end
                    end
                end
            end
            OP_READ_CELL: begin
                rd = 1'b1;
                rd_val = tape_img[w.position];
            end
            default: begin
            end
        endcase
        o = '0;
        o.state_now = tm_state;
        o.head_now = tm_head;
        o.is_halted = tm_halted;
        o.seen_symbol = rd ? rd_val : tape_img[tm_head];
        o.status = sts;
    endtask

    function automatic in_word_t mk_word(input logic [OP_W-1:0] op, input int unsigned rs,
            input int unsigned sym, input int unsigned wsym, input logic [MOVE_W-1:0] mv,
            input int unsigned nq, input int unsigned pos);
        in_word_t w;
        w = '0;
        w.op = op;
        w.rule_state = STATE_W'(rs);
        w.rule_symbol = SYM_W'(sym);
        w.write_symbol = SYM_W'(wsym);
        w.move = mv;
        w.next_state = STATE_W'(nq);
        w.position = POS_W'(pos);
        return w;
    endfunction

    function automatic out_word_t mk_report(input int unsigned st, input int unsigned hd,
            input bit hl, input int unsigned seen, input logic [STATUS_W-1:0] sts);
        out_word_t r;
        r = '0;
        r.state_now = STATE_W'(st);
        r.head_now = POS_W'(hd);
        r.is_halted = hl;
        r.seen_symbol = SYM_W'(seen);
        r.status = sts;
        return r;
    endfunction

    task automatic add_typed(input in_word_t w, input out_word_t want);
        dir_rows.push_back('{w: w, typed: 1'b1, want: want});
    endtask

    task automatic add_free(input in_word_t w);
        dir_rows.push_back('{w: w, typed: 1'b0, want: '0});
    endtask

    function automatic logic [SYM_W-1:0] pick_sym();
        logic [SYM_W-1:0] s;
        repeat (8) begin
            s = SYM_W'($urandom_range(0, 2**SYM_W - 1));
            if (sym_allowed(s)) return s;
        end
        return BLANK_CODE;
    endfunction

    function automatic logic [STATE_W-1:0] pick_state();
        logic [STATE_W-1:0] q;
        repeat (16) begin
            q = STATE_W'($urandom_range(0, 2**STATE_W - 1));
            if (next_allowed(q)) return q;
        end
        return cfg_halt;
    endfunction

    function automatic logic [MOVE_W-1:0] pick_move();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return MV_STAY;
        if (r == 1) return MV_CODE3;
        return (r < 6) ? MV_LEFT : MV_RIGHT;
    endfunction

    function automatic in_word_t draw_word();
        in_word_t w;
        int unsigned r;
        logic [SYM_W-1:0] under;
        w = in_word_t'($urandom);
        w.pad = '0;
        r = $urandom_range(0, 99);
        under = tape_img[tm_head];
        if (tm_halted && $urandom_range(0, 1) == 1) w.op = OP_RESET_RUN;
        else if (r < 47) w.op = OP_STEP;
        else if (r < 69) w.op = OP_LOAD_RULE;
        else if (r < 78) w.op = OP_WRITE_CELL;
        else if (r < 86) w.op = OP_READ_CELL;
        else if (r < 92) w.op = OP_SET_HEAD;
        else if (r < 94) w.op = OP_CLEAR_RULES;
        else if (r < 98) w.op = OP_RESET_RUN;
        else w.op = OP_UNDEFINED;
        if (w.op == OP_LOAD_RULE && $urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 1) == 1) w.rule_state = tm_state;
            if (sym_allowed(under) && $urandom_range(0, 1) == 1) w.rule_symbol = under;
            else w.rule_symbol = pick_sym();
            w.write_symbol = pick_sym();
            w.next_state = pick_state();
            w.move = pick_move();
        end
        if (w.op == OP_SET_HEAD && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 1) w.position = POS_W'($urandom_range(0, 1));
            else w.position = LAST_CELL - POS_W'($urandom_range(0, 1));
        end
        if (w.op == OP_WRITE_CELL && $urandom_range(0, 1) == 1) w.position = tm_head;
        return w;
    endfunction

    function automatic int unsigned tx_gap();
        int unsigned r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic issue(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t pred;
        int unsigned gap;
        s_tdata <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tm_apply(w, pred);
        report_q.push_back(typed ? want : pred);
        gap = tx_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] a, input int unsigned v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= CFG_DATA_W'(v);
        @(posedge aclk);
        case (a)
            CFG_INITIAL_STATE: cfg_init = STATE_W'(v);
            CFG_HALT_STATE:    cfg_halt = STATE_W'(v);
            CFG_ALPHABET_MASK: cfg_alpha = (2**SYM_W)'(v);
            CFG_STATE_MASK:    cfg_smask = (2**STATE_W)'(v);
            CFG_START_INDEX:   cfg_start = POS_W'(v);
            default: begin
            end
        endcase
    endtask

    task automatic start_phase(input int unsigned init, input int unsigned halt,
            input int unsigned alpha, input int unsigned smask, input int unsigned start);
        settle();
        write_cfg(CFG_INITIAL_STATE, init);
        write_cfg(CFG_HALT_STATE, halt);
        write_cfg(CFG_ALPHABET_MASK, alpha);
        write_cfg(CFG_STATE_MASK, smask);
        write_cfg(CFG_START_INDEX, start);
        cfg_wr_en <= 1'b0;
        issue(mk_word(OP_RESET_RUN, 0, 0, 0, MV_STAY, 0, 0), 1'b0, '0);
    endtask

    task automatic run_random(input int unsigned n);
        repeat (n) issue(draw_word(), 1'b0, '0);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
            input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_got = m_tdata;
            if (report_q.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                rx_want = report_q.pop_front();
                check_field("state_now", 16'(rx_want.state_now), 16'(rx_got.state_now));
                check_field("head_now", 16'(rx_want.head_now), 16'(rx_got.head_now));
                check_field("is_halted", 16'(rx_want.is_halted), 16'(rx_got.is_halted));
                check_field("seen_symbol", 16'(rx_want.seen_symbol), 16'(rx_got.seen_symbol));
                check_field("status", 16'(rx_want.status), 16'(rx_got.status));
            end
        end
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            rx_wait = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else if (rx_calm) begin
            m_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_wait = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        cfg_init = RST_INITIAL_STATE;
        cfg_halt = RST_HALT_STATE;
        cfg_alpha = RST_ALPHABET_MASK;
        cfg_smask = RST_STATE_MASK;
        cfg_start = RST_START_INDEX;
        foreach (rule_ok[i]) rule_ok[i] = 1'b0;
        foreach (tape_img[i]) tape_img[i] = BLANK_CODE;
        tm_head = RST_START_INDEX;
        tm_state = RST_INITIAL_STATE;
        tm_halted = 1'b0;

        // Default configuration: only blank is a legal symbol, states 0 and 1 are legal.
        add_typed(mk_word(OP_READ_CELL, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(0, 512, 0, 0, STS_OK));
        add_typed(mk_word(OP_STEP, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(0, 512, 1, 0, STS_NO_RULE));
        add_typed(mk_word(OP_STEP, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(0, 512, 1, 0, STS_HALTED));
        add_typed(mk_word(OP_UNDEFINED, 15, 7, 7, MV_CODE3, 15, 1023),
                  mk_report(0, 512, 1, 0, STS_OK));
        add_typed(mk_word(OP_LOAD_RULE, 0, 1, 0, MV_STAY, 0, 0),
                  mk_report(0, 512, 1, 0, STS_REJECTED));
        add_typed(mk_word(OP_LOAD_RULE, 0, 0, 7, MV_STAY, 0, 0),
                  mk_report(0, 512, 1, 0, STS_REJECTED));
        add_typed(mk_word(OP_LOAD_RULE, 0, 0, 0, MV_STAY, 15, 0),
                  mk_report(0, 512, 1, 0, STS_REJECTED));
        add_free(mk_word(OP_LOAD_RULE, 15, 0, 0, MV_CODE3, 0, 0));
        add_typed(mk_word(OP_WRITE_CELL, 0, 7, 0, MV_STAY, 0, 1023),
                  mk_report(0, 512, 1, 0, STS_OK));
        add_typed(mk_word(OP_READ_CELL, 0, 0, 0, MV_STAY, 0, 1023),
                  mk_report(0, 512, 1, 7, STS_OK));
        add_typed(mk_word(OP_SET_HEAD, 0, 0, 0, MV_STAY, 0, 1023),
                  mk_report(0, 1023, 1, 7, STS_OK));
        add_typed(mk_word(OP_RESET_RUN, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(0, 512, 0, 0, STS_OK));
        add_typed(mk_word(OP_READ_CELL, 0, 0, 0, MV_STAY, 0, 1023),
                  mk_report(0, 512, 0, 0, STS_OK));
        add_free(mk_word(OP_LOAD_RULE, 0, 0, 0, MV_LEFT, 0, 0));
        add_free(mk_word(OP_SET_HEAD, 0, 0, 0, MV_STAY, 0, 0));
        add_typed(mk_word(OP_STEP, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(0, 0, 1, 0, STS_OFF_TAPE));
        add_free(mk_word(OP_RESET_RUN, 0, 0, 0, MV_STAY, 0, 0));
        add_free(mk_word(OP_LOAD_RULE, 0, 0, 0, MV_RIGHT, 1, 0));
        add_free(mk_word(OP_SET_HEAD, 0, 0, 0, MV_STAY, 0, 1023));
        add_typed(mk_word(OP_STEP, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(1, 1023, 1, 0, STS_OFF_TAPE));
        add_free(mk_word(OP_RESET_RUN, 0, 0, 0, MV_STAY, 0, 0));
        add_typed(mk_word(OP_STEP, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(1, 513, 1, 0, STS_HALT));
        add_free(mk_word(OP_RESET_RUN, 0, 0, 0, MV_STAY, 0, 0));
        add_free(mk_word(OP_LOAD_RULE, 0, 0, 0, MV_CODE3, 0, 0));
        add_typed(mk_word(OP_STEP, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(0, 512, 0, 0, STS_OK));
        add_free(mk_word(OP_CLEAR_RULES, 0, 0, 0, MV_STAY, 0, 0));
        add_typed(mk_word(OP_STEP, 0, 0, 0, MV_STAY, 0, 0),
                  mk_report(0, 512, 1, 0, STS_NO_RULE));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir_rows[i]) issue(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

        start_phase(0, 15, 8'hFF, 16'hFFFF, 512);
        run_random(PHASE_WORDS);
        start_phase(15, 0, 8'h00, 16'h0000, 0);
        run_random(PHASE_WORDS);
        start_phase($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
                    $urandom_range(0, 65535), 1023);
        run_random(PHASE_WORDS);

        // The sink holds off for longer than a tape clear while words keep coming.
        start_phase($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
                    $urandom_range(0, 65535), $urandom_range(0, 1023));
        tx_calm = 1'b1;
        hold_token++;
        run_random(PHASE_WORDS);
        tx_calm = 1'b0;

        start_phase($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
                    $urandom_range(0, 65535), $urandom_range(0, 1023));
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_random(PHASE_WORDS);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        start_phase($urandom_range(0, 15), $urandom_range(0, 15), 8'hFF, 16'hFFFF,
                    $urandom_range(0, 1023));
        run_random(PHASE_WORDS);

        settle();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
